// ===== rtl/core/lcswb_pkg.sv =====
// Shared constants and types for the lagged CSWB random generator.
// No dependencies; imported by every module of the block except lcswb_ram.
`timescale 1ns / 1ps

package lcswb_pkg;

   localparam int QUEUE_DEPTH = 1220;
   localparam int SHORT_LAG   = 30;
   localparam int VAL_W       = 53;
   localparam int FILL_BITS   = 52;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int STEP_W      = $clog2(FILL_BITS);

   localparam logic [VAL_W-1:0] SWB_SEED_OLDER = 53'd5212886298506819;
   localparam logic [VAL_W-1:0] SWB_SEED_NEWER = 53'd2020898595989513;
   localparam logic [31:0]      XS_SEED        = 32'd362436069;
   localparam logic [31:0]      LCG_DEFAULT    = 32'd123456789;
   localparam logic [31:0]      LCG_MUL        = 32'd69069;
   localparam logic [31:0]      LCG_INC        = 32'd123;
   localparam int               SAMPLE_BIT     = 23;

   localparam logic MODE_SEED = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [VAL_W-1:0] word;
   } seed_word_type;

endpackage

// ===== rtl/core/lcswb_ram.sv =====
// Generic synchronous RAM, one write port and two registered read ports.
// Standalone; no package needed.
`timescale 1ns / 1ps

module lcswb_ram #(
   parameter int DEPTH  = 1220,
   parameter int WIDTH  = 53,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   output logic [WIDTH-1:0]  rd_data_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== rtl/core/lcswb_seed_gen.sv =====
// Seed word generator: congruential plus xorshift, one bit per cycle.
// Depends on lcswb_pkg; emits 53-bit queue words of 52 generated bits above a zero low bit.
`timescale 1ns / 1ps

module lcswb_seed_gen (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             seed,
   output lcswb_pkg::seed_word_type seed_word
);
   import lcswb_pkg::*;

   logic              run_ff;
   logic [31:0]       x_ff;
   logic [31:0]       y_ff;
   logic [STEP_W-1:0] step_ff;
   logic [IDX_W-1:0]  word_ff;
   logic              bv_ff;
   logic              blast_ff;
   logic              wlast_ff;
   logic [FILL_BITS-2:0] acc_ff;

   logic [31:0] x_in;
   logic [31:0] y1, y2, y_in;
   logic [31:0] sum;
   logic        bit_now;
   logic        last_step;
   logic        last_word;

   always_comb begin
      x_in      = x_ff * LCG_MUL + LCG_INC;
      y1        = y_ff ^ (y_ff << 13);
      y2        = y1 ^ (y1 >> 17);
      y_in      = y2 ^ (y2 << 5);
      sum       = x_ff + y_ff;
      bit_now   = sum[SAMPLE_BIT];
      last_step = (step_ff == STEP_W'(FILL_BITS - 1));
      last_word = (word_ff == IDX_W'(QUEUE_DEPTH - 1));
      seed_word.valid = bv_ff && blast_ff;
      seed_word.last  = bv_ff && blast_ff && wlast_ff;
      seed_word.word  = {acc_ff, bit_now, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         bv_ff   <= 1'b0;
         x_ff    <= '0;
         y_ff    <= XS_SEED;
         step_ff <= '0;
         word_ff <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         bv_ff   <= 1'b0;
         x_ff    <= (seed == 32'd0) ? LCG_DEFAULT : seed;
         y_ff    <= XS_SEED;
         step_ff <= '0;
         word_ff <= '0;
      end else if (run_ff) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         bv_ff    <= 1'b1;
         blast_ff <= last_step;
         wlast_ff <= last_step && last_word;
         if (last_step) begin
            step_ff <= '0;
            word_ff <= word_ff + 1'b1;
            if (last_word) begin
               run_ff <= 1'b0;
            end
         end else begin
            step_ff <= step_ff + 1'b1;
         end
      end else begin
         bv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (bv_ff) begin
         acc_ff <= {acc_ff[FILL_BITS-3:0], bit_now};
      end
   end

endmodule

// ===== rtl/core/lagged_cswb_random_generator.sv =====
// Lagged CSWB random generator, top level. Depends on lcswb_pkg, lcswb_ram, lcswb_seed_gen.
// Draw: the result is registered from S_READ or S_FINISH; requests stall until S_IDLE.
// Every QUEUE_DEPTH draws a refill walks the queue RAM, one entry per cycle.
// Seed: paced by the one-bit-per-cycle seed generator; no result.
// Reset clears control state; queue RAM is undefined until the first seed fills it.
`timescale 1ns / 1ps

module lagged_cswb_random_generator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [31:0]                 req_seed,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lcswb_pkg::VAL_W-1:0] rsp_value
);
   import lcswb_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEED,
      S_REFILL,
      S_READ,
      S_FINISH
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  read_index_ff;
   logic              carry_ff;
   logic              borrow_ff;
   logic [VAL_W-1:0]  older_ff;
   logic [VAL_W-1:0]  newer_ff;
   logic              seeded_ff;
   logic [IDX_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  iss_ff;
   logic              wv_ff;
   logic [IDX_W-1:0]  widx_ff;
   logic              fwd_ff;
   logic [VAL_W-1:0]  fwd_data_ff;
   logic [VAL_W-1:0]  q_ff;
   logic              rsp_valid_ff;
   logic [VAL_W-1:0]  rsp_value_ff;

   seed_word_type     seed_word;
   logic              accept;
   logic              seed_start;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic [IDX_W-1:0]  rd_addr_a;
   logic [IDX_W-1:0]  rd_addr_b;
   logic [VAL_W-1:0]  rd_data_a;
   logic [VAL_W-1:0]  rd_data_b;
   logic [CNT_W-1:0]  j_full;
   logic [VAL_W-1:0]  lag_data;
   logic [VAL_W:0]    cs_sum;
   logic [VAL_W:0]    swb_diff;
   logic [VAL_W-1:0]  q_cur;
   logic [VAL_W-1:0]  out_val_in;
   logic              slot_free;
   logic              fwd_in;

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign seed_start = accept && (req_mode == MODE_SEED);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;

   always_comb begin
      j_full = (iss_ff < CNT_W'(SHORT_LAG)) ? iss_ff + CNT_W'(QUEUE_DEPTH - SHORT_LAG)
                                            : iss_ff - CNT_W'(SHORT_LAG);
      rd_addr_b = j_full[IDX_W-1:0];
      rd_addr_a = (state_ff == S_REFILL) ? iss_ff[IDX_W-1:0] : read_index_ff[IDX_W-1:0];
      lag_data  = fwd_ff ? fwd_data_ff : rd_data_b;
      // j - i + carry - 1, and its carry out marks j - i + carry > 0
      cs_sum    = {1'b0, lag_data} + {1'b0, ~rd_data_a} + {{VAL_W{1'b0}}, carry_ff};
      swb_diff  = {1'b0, older_ff} - {1'b0, newer_ff} - {{VAL_W{1'b0}}, borrow_ff};
      q_cur      = (state_ff == S_READ) ? rd_data_a : q_ff;
      out_val_in = q_cur - newer_ff;
      slot_free  = !rsp_valid_ff || !rsp_stall;
      if (state_ff == S_SEED) begin
         wr_en   = seed_word.valid;
         wr_addr = fill_ff;
         wr_data = seed_word.word;
      end else begin
         wr_en   = (state_ff == S_REFILL) && wv_ff;
         wr_addr = widx_ff;
         wr_data = cs_sum[VAL_W-1:0];
      end
      fwd_in = wr_en && (wr_addr == rd_addr_b);
   end

   lcswb_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (VAL_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   lcswb_seed_gen u_seed_gen (
      .clock     (clock),
      .reset     (reset),
      .start     (seed_start),
      .seed      (req_seed),
      .seed_word (seed_word)
   );

   always_ff @(posedge clock) begin
      fwd_ff      <= fwd_in;
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         read_index_ff <= CNT_W'(QUEUE_DEPTH);
         carry_ff      <= 1'b0;
         borrow_ff     <= 1'b0;
         older_ff      <= SWB_SEED_OLDER;
         newer_ff      <= SWB_SEED_NEWER;
         seeded_ff     <= 1'b0;
         fill_ff       <= '0;
         iss_ff        <= '0;
         wv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !(state_ff inside {S_READ, S_FINISH})) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_mode == MODE_SEED) begin
                     state_ff      <= S_SEED;
                     fill_ff       <= '0;
                     carry_ff      <= 1'b0;
                     borrow_ff     <= 1'b0;
                     older_ff      <= SWB_SEED_OLDER;
                     newer_ff      <= SWB_SEED_NEWER;
                     read_index_ff <= CNT_W'(QUEUE_DEPTH);
                     seeded_ff     <= 1'b1;
                  end else if (seeded_ff) begin
                     older_ff  <= newer_ff;
                     newer_ff  <= swb_diff[VAL_W-1:0];
                     borrow_ff <= swb_diff[VAL_W];
                     if (read_index_ff < CNT_W'(QUEUE_DEPTH)) begin
                        read_index_ff <= read_index_ff + 1'b1;
                        state_ff      <= S_READ;
                     end else begin
                        iss_ff   <= '0;
                        wv_ff    <= 1'b0;
                        state_ff <= S_REFILL;
                     end
                  end
               end
            end
            S_SEED: begin
               if (seed_word.valid) begin
                  fill_ff <= fill_ff + 1'b1;
                  if (seed_word.last) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_REFILL: begin
               if (iss_ff < CNT_W'(QUEUE_DEPTH)) begin
                  iss_ff  <= iss_ff + 1'b1;
                  widx_ff <= iss_ff[IDX_W-1:0];
                  wv_ff   <= 1'b1;
               end else begin
                  wv_ff <= 1'b0;
               end
               if (wv_ff) begin
                  carry_ff <= cs_sum[VAL_W];
                  if (widx_ff == '0) begin
                     q_ff <= cs_sum[VAL_W-1:0];
                  end
                  if (widx_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
                     read_index_ff <= CNT_W'(1);
                     state_ff      <= S_FINISH;
                  end
               end
            end
            S_READ, S_FINISH: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= out_val_in;
                  state_ff     <= S_IDLE;
               end else begin
                  q_ff     <= q_cur;
                  state_ff <= S_FINISH;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/lcswb_checker.sv =====
// Port-level checks for the lagged CSWB random generator.
// Depends on lcswb_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module lcswb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_mode,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [lcswb_pkg::VAL_W-1:0] rsp_value
);
   import lcswb_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("stalled response beat changed");

   a_seed_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_mode == MODE_SEED) |=> req_stall)
      else $error("request taken right after a seed beat");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after a request beat");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response rose while the block was idle");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind lagged_cswb_random_generator lcswb_checker u_checker (.*);

// ===== test/testbench.sv =====
// Testbench for lagged_cswb_random_generator: seeds and draws over the valid/stall channels.
// A scoreboard class predicts every drawn fraction and checks results in order.
// Depends on lcswb_pkg and the generator RTL.
`timescale 1ns / 1ps

module testbench;
   import lcswb_pkg::*;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int RANDOM_ITEMS = 1550;
   localparam int PRESSURE_LEN = 60;
   localparam int MAX_RANDOM_SEEDS = 3;

   class fraction_scoreboard;
      bit [VAL_W-1:0] lag_q [QUEUE_DEPTH];
      int unsigned    next_idx;
      bit             carry;
      bit             borrow;
      bit [VAL_W-1:0] swb_old;
      bit [VAL_W-1:0] swb_new;
      bit             seeded;
      bit [31:0]      lcg_state;
      bit [31:0]      xs_state;
      bit [VAL_W-1:0] pending_fractions [$];
      int             errors;

      function new();
         foreach (lag_q[i]) lag_q[i] = '0;
         next_idx  = QUEUE_DEPTH;
         carry     = 1'b0;
         borrow    = 1'b0;
         swb_old   = SWB_SEED_OLDER;
         swb_new   = SWB_SEED_NEWER;
         seeded    = 1'b0;
         lcg_state = '0;
         xs_state  = XS_SEED;
         errors    = 0;
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function void seed_lag_queue(bit [31:0] seed_word);
         bit [31:0]      x;
         bit [31:0]      y;
         bit [31:0]      sum;
         bit [VAL_W-1:0] s;
         x = (seed_word == 32'd0) ? LCG_DEFAULT : seed_word;
         y = XS_SEED;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            s = '0;
            for (int b = 0; b < FILL_BITS; b++) begin
               x = LCG_MUL * x + LCG_INC;
               y = y ^ (y << 13);
               y = y ^ (y >> 17);
               y = y ^ (y << 5);
               sum = x + y;
               if (sum[SAMPLE_BIT]) s[VAL_W-1-b] = 1'b1;
            end
            lag_q[i] = s;
         end
         lcg_state = x;
         xs_state  = y;
         carry     = 1'b0;
         borrow    = 1'b0;
         swb_old   = SWB_SEED_OLDER;
         swb_new   = SWB_SEED_NEWER;
         next_idx  = QUEUE_DEPTH;
         seeded    = 1'b1;
      endfunction

      function void refill_lag_queue();
         longint      one_fix;
         longint      t;
         int unsigned j;
         one_fix = longint'(1) << VAL_W;
         for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
            j = (i < SHORT_LAG) ? i + (QUEUE_DEPTH - SHORT_LAG) : i - SHORT_LAG;
            t = longint'(lag_q[j]) - longint'(lag_q[i]) + longint'(carry);
            if (t > 0) begin
               t = t - 1;
               carry = 1'b1;
            end else begin
               t = t - 1 + one_fix;
               carry = 1'b0;
            end
            lag_q[i] = t[VAL_W-1:0];
         end
      endfunction

      function bit [VAL_W-1:0] next_fraction();
         longint         one_fix;
         longint         d;
         bit [VAL_W-1:0] q;
         one_fix = longint'(1) << VAL_W;
         d = longint'(swb_old) - longint'(swb_new) - longint'(borrow);
         swb_old = swb_new;
         if (d < 0) begin
            d = d + one_fix;
            swb_new = d[VAL_W-1:0];
            borrow = 1'b1;
         end else begin
            swb_new = d[VAL_W-1:0];
            borrow = 1'b0;
         end
         if (next_idx < QUEUE_DEPTH) begin
            q = lag_q[next_idx];
            next_idx++;
         end else begin
            refill_lag_queue();
            next_idx = 1;
            q = lag_q[0];
         end
         return q - swb_new;
      endfunction

      function void note_request(bit mode, bit [31:0] seed_word);
         if (mode == MODE_SEED) seed_lag_queue(seed_word);
         else if (seeded) pending_fractions.push_back(next_fraction());
      endfunction

      task check_fraction(bit [VAL_W-1:0] got);
         bit [VAL_W-1:0] want;
         if (pending_fractions.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%h", got));
         end else begin
            want = pending_fractions.pop_front();
            if (got !== want)
               report_mismatch($sformatf("value=%h expected %h", got, want));
         end
      endtask
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_mode  = MODE_DRAW;
   logic [31:0]      req_seed  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [VAL_W-1:0] rsp_value;

   fraction_scoreboard sb = new();
   bit steady_flow   = 1'b0;
   int hold_request  = 0;
   int cycle_count   = 0;

   lagged_cswb_random_generator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_seed  (req_seed),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_value (rsp_value)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // called at a falling edge; returns at a falling edge after the beat and its pick_gap idle gap
   task automatic send_beat(input logic mode, input logic [31:0] seed_word);
      int gap;
      req_mode  <= mode;
      req_seed  <= seed_word;
      req_valid <= 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_request(mode, seed_word);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_draws(input int count);
      for (int i = 0; i < count; i++) send_beat(MODE_DRAW, $urandom());
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_fraction(rsp_value);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : receiver
      int stall_left;
      int open_left;
      int hold_left;
      bit hold_taken;
      stall_left = 0;
      open_left  = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0 && !hold_taken) begin
            hold_left  = hold_request;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (open_left > 0) begin
            rsp_stall <= 1'b0;
            open_left--;
         end else begin
            rsp_stall <= 1'b0;
            open_left  = steady_flow ? 40 : $urandom_range(0, 12);
            stall_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      int seeds_left;
      int steady_left;
      logic mode;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // draws before any seed give nothing
      send_beat(MODE_DRAW, 32'h0000_0000);
      send_beat(MODE_DRAW, 32'hFFFF_FFFF);
      // zero seed falls back to the default
      send_beat(MODE_SEED, 32'h0000_0000);
      send_draws(6);
      send_beat(MODE_SEED, 32'hFFFF_FFFF);
      send_draws(5);
      // reseed with an arbitrary value; xorshift restarts
      send_beat(MODE_SEED, $urandom());
      send_draws(4);

      // receiver holds off while draws keep coming
      steady_flow  = 1'b1;
      hold_request = 400;
      send_draws(PRESSURE_LEN);
      steady_flow  = 1'b0;

      seeds_left  = MAX_RANDOM_SEEDS;
      steady_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (steady_left > 0) begin
            steady_left--;
            if (steady_left == 0) steady_flow = 1'b0;
         end else if ($urandom_range(0, 49) == 0) begin
            steady_left = $urandom_range(20, 80);
            steady_flow = 1'b1;
         end
         mode = MODE_DRAW;
         if (seeds_left > 0 && $urandom_range(0, 499) == 0) begin
            mode = MODE_SEED;
            seeds_left--;
         end
         send_beat(mode, $urandom());
      end
      send_draws(2);
      req_valid <= 1'b0;

      while (sb.pending_fractions.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      while (sb.pending_fractions.size() != 0)
         sb.report_mismatch($sformatf("missing result, expected %h",
                                      sb.pending_fractions.pop_front()));
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
